// ===== rtl/core/ycr2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// ycr2rgb_pkg
// Shared types, constants and tables for the YCbCr to RGB converter.
// ----------------------------------------------------------------------------
package ycr2rgb_pkg;

    localparam int OFB_DEFAULT = 12;

    // Register indexes on the configuration port
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR_MATRIX  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FULL_RANGE    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_FORMAT = 2'd2;

    // Matrix codes
    localparam logic [1:0] MTX_BT709  = 2'd0;
    localparam logic [1:0] MTX_BT601  = 2'd1;
    localparam logic [1:0] MTX_BT2020 = 2'd2;

    localparam int SAMPLE_BITS = 16;
    localparam int CODE_BITS   = 10;
    localparam int NORM_BITS   = 16;
    localparam int COEF_BITS   = 14;
    localparam int NUM_BITS    = 26;    // magnitude << 16 plus half divisor
    localparam int DEN_BITS    = 11;
    localparam int RCP_SHIFT   = 27;
    localparam int RCP_BITS    = 20;
    localparam int QUO_BITS    = 17;    // largest quotient is below 2^17
    localparam int NORM_W      = QUO_BITS + 1;
    localparam int CHAN_BITS   = 31;    // clamped channel, 0..2^30
    localparam logic [CHAN_BITS-1:0] CHAN_ONE = 31'h4000_0000;

    // Divisors and their truncated reciprocals 2^27 / d
    localparam logic [DEN_BITS-1:0] DEN_255  = 11'd255;
    localparam logic [DEN_BITS-1:0] DEN_1023 = 11'd1023;
    localparam logic [DEN_BITS-1:0] DEN_510  = 11'd510;
    localparam logic [DEN_BITS-1:0] DEN_2046 = 11'd2046;
    localparam logic [DEN_BITS-1:0] DEN_219  = 11'd219;
    localparam logic [DEN_BITS-1:0] DEN_876  = 11'd876;
    localparam logic [DEN_BITS-1:0] DEN_224  = 11'd224;
    localparam logic [DEN_BITS-1:0] DEN_896  = 11'd896;
    localparam logic [RCP_BITS-1:0] RCP_255  = RCP_BITS'((1 << RCP_SHIFT) / 255);
    localparam logic [RCP_BITS-1:0] RCP_1023 = RCP_BITS'((1 << RCP_SHIFT) / 1023);
    localparam logic [RCP_BITS-1:0] RCP_510  = RCP_BITS'((1 << RCP_SHIFT) / 510);
    localparam logic [RCP_BITS-1:0] RCP_2046 = RCP_BITS'((1 << RCP_SHIFT) / 2046);
    localparam logic [RCP_BITS-1:0] RCP_219  = RCP_BITS'((1 << RCP_SHIFT) / 219);
    localparam logic [RCP_BITS-1:0] RCP_876  = RCP_BITS'((1 << RCP_SHIFT) / 876);
    localparam logic [RCP_BITS-1:0] RCP_224  = RCP_BITS'((1 << RCP_SHIFT) / 224);
    localparam logic [RCP_BITS-1:0] RCP_896  = RCP_BITS'((1 << RCP_SHIFT) / 896);

    typedef struct packed {
        logic [NUM_BITS-1:0] num;   // |n| * 2^16 + d/2
        logic                neg;
        logic [DEN_BITS-1:0] den;
        logic [RCP_BITS-1:0] rcp;
    } t_div_in;

    typedef struct packed {
        logic est;                  // advance the estimate stage
        logic fix;                  // advance the correction stage
    } t_div_adv;

    typedef struct packed {
        logic signed [15:0] r_cr;
        logic signed [15:0] g_cb;
        logic signed [15:0] g_cr;
        logic signed [15:0] b_cb;
    } t_coef;

    function automatic t_coef matrix_coef(input logic [1:0] mtx);
        t_coef k;
        unique case (mtx)
            MTX_BT601: begin
                k.r_cr = 16'sd22970;  k.g_cb = -16'sd5638;
                k.g_cr = -16'sd11700; k.b_cb = 16'sd29032;
            end
            MTX_BT2020: begin
                k.r_cr = 16'sd24160;  k.g_cb = -16'sd2696;
                k.g_cr = -16'sd9361;  k.b_cb = 16'sd30825;
            end
            default: begin
                // BT.709, also for the unused code
                k.r_cr = 16'sd25802;  k.g_cb = -16'sd3069;
                k.g_cr = -16'sd7670;  k.b_cb = 16'sd30402;
            end
        endcase
        return k;
    endfunction

    // Pick the code out of a sample, form the signed numerator and the
    // divisor for range normalization.
    function automatic t_div_in div_setup(input logic [SAMPLE_BITS-1:0] smp,
                                          input logic chroma, input logic full,
                                          input logic p010);
        t_div_in          d;
        logic [CODE_BITS-1:0] code;
        logic signed [11:0] cs;
        logic signed [11:0] n;
        logic [11:0]      mag;
        code = p010 ? smp[15:6] : {2'b00, smp[7:0]};
        cs   = $signed({2'b00, code});
        unique case ({p010, full, chroma})
            3'b000: begin n = cs - 12'sd16;  d.den = DEN_219;  d.rcp = RCP_219;  end
            3'b001: begin n = cs - 12'sd128; d.den = DEN_224;  d.rcp = RCP_224;  end
            3'b010: begin n = cs;            d.den = DEN_255;  d.rcp = RCP_255;  end
            3'b011: begin n = (cs <<< 1) - 12'sd255;  d.den = DEN_510;  d.rcp = RCP_510; end
            3'b100: begin n = cs - 12'sd64;  d.den = DEN_876;  d.rcp = RCP_876;  end
            3'b101: begin n = cs - 12'sd512; d.den = DEN_896;  d.rcp = RCP_896;  end
            3'b110: begin n = cs;            d.den = DEN_1023; d.rcp = RCP_1023; end
            default: begin n = (cs <<< 1) - 12'sd1023; d.den = DEN_2046; d.rcp = RCP_2046; end
        endcase
        d.neg = n[11];
        mag   = n[11] ? 12'(-n) : 12'(n);
        d.num = {mag[CODE_BITS-1:0], {NORM_BITS{1'b0}}} + NUM_BITS'(d.den >> 1);
        return d;
    endfunction

endpackage

// ===== rtl/core/ycr2rgb_pix_if.sv =====
// ----------------------------------------------------------------------------
// ycr2rgb_pix_if
// Pixel channel carrying one Y, Cb, Cr sample triple per beat.
// ----------------------------------------------------------------------------
interface ycr2rgb_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] luma_sample;
    logic [15:0] cb_sample;
    logic [15:0] cr_sample;

    modport source (output valid, output luma_sample, output cb_sample,
                    output cr_sample, input ready);
    modport sink   (input valid, input luma_sample, input cb_sample,
                    input cr_sample, output ready);
endinterface

// ===== rtl/core/ycr2rgb_rgb_if.sv =====
// ----------------------------------------------------------------------------
// ycr2rgb_rgb_if
// Result channel carrying one clamped RGB triple per beat.
// ----------------------------------------------------------------------------
interface ycr2rgb_rgb_if #(
    parameter int LEVEL_BITS = ycr2rgb_pkg::OFB_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] red_level;
    logic [LEVEL_BITS-1:0] green_level;
    logic [LEVEL_BITS-1:0] blue_level;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, input ready);
    modport sink   (input valid, input red_level, input green_level,
                    input blue_level, output ready);
endinterface

// ===== rtl/core/ycbcr_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_converter
// YCbCr to RGB pixel converter for NV12 and P010 samples, full or limited
// range, with BT.709, BT.601 and BT.2020 matrices.
//
// The converter takes one pixel per clock while the output side is ready and
// returns one RGB beat per pixel, in order, through a six-register pipeline
// (code select, reciprocal estimate, quotient correction, matrix multiply,
// sum and clamp, level scaling); throughput is one pixel per cycle unless
// the output stalls. Each stage holds a valid bit, so a stall on the output
// stops only the stages that are full and empty slots still fill.
// Samples are normalized to Q.16 with round-half-away-from-zero, multiplied
// by Q2.14 coefficients, clamped to 0..1 and scaled to OUT_FRACTION_BITS-bit
// levels with round to nearest. Configuration registers (matrix, range,
// sample format) are written through a plain write port and must be changed
// only while the pipeline is empty. Matrix code 3 selects BT.709.
// ----------------------------------------------------------------------------
module ycbcr_to_rgb_converter #(
    parameter int OUT_FRACTION_BITS = ycr2rgb_pkg::OFB_DEFAULT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ycr2rgb_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [ycr2rgb_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    ycr2rgb_pix_if.sink                            i_pix,
    ycr2rgb_rgb_if.source                          o_rgb
);
    import ycr2rgb_pkg::*;

    localparam int NSTG      = 6;
    localparam int BASE_BITS = NORM_W + COEF_BITS;
    localparam int PRD_BITS  = NORM_W + 16;
    localparam int SUM_BITS  = PRD_BITS + 2;
    localparam int LVL_PROD  = CHAN_BITS + OUT_FRACTION_BITS;
    localparam logic [OUT_FRACTION_BITS-1:0] LVL_TOP = '1;

    // Configuration registers
    logic [1:0] r_color_matrix;
    logic       r_full_range;
    logic       r_sample_format;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_matrix  <= MTX_BT709;
            r_full_range    <= 1'b0;
            r_sample_format <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COLOR_MATRIX:  r_color_matrix  <= i_cfg_wdata[1:0];
                CFG_FULL_RANGE:    r_full_range    <= i_cfg_wdata[0];
                CFG_SAMPLE_FORMAT: r_sample_format <= i_cfg_wdata[0];
                default: ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // Pipeline control: a stage advances when it is empty or its successor
    // advances, so bubbles squeeze out under back-pressure.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || o_rgb.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
        for (int k = 0; k < NSTG; k++) begin
            if (adv[k]) begin
                n_vld[k] = (k == 0) ? i_pix.valid : r_vld[k-1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_pix.ready = adv[0];

    // Stage 0: extract codes, build numerator and divisor per channel
    t_div_in r_div_y, r_div_cb, r_div_cr;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_div_y  <= div_setup(i_pix.luma_sample, 1'b0, r_full_range, r_sample_format);
            r_div_cb <= div_setup(i_pix.cb_sample,   1'b1, r_full_range, r_sample_format);
            r_div_cr <= div_setup(i_pix.cr_sample,   1'b1, r_full_range, r_sample_format);
        end
    end

    // Stages 1 and 2: normalize to Q.16
    t_div_adv w_div_adv;
    logic signed [NORM_W-1:0] w_y, w_cb, w_cr;

    assign w_div_adv.est = adv[1];
    assign w_div_adv.fix = adv[2];

    ycr2rgb_norm_div u_div_y  (.i_clk(i_clk), .i_adv(w_div_adv), .i_div(r_div_y),  .o_quo(w_y));
    ycr2rgb_norm_div u_div_cb (.i_clk(i_clk), .i_adv(w_div_adv), .i_div(r_div_cb), .o_quo(w_cb));
    ycr2rgb_norm_div u_div_cr (.i_clk(i_clk), .i_adv(w_div_adv), .i_div(r_div_cr), .o_quo(w_cr));

    // Stage 3: matrix products in Q.30
    t_coef w_k;
    logic signed [BASE_BITS-1:0] r_base;
    logic signed [PRD_BITS-1:0]  r_p_rcr, r_p_gcb, r_p_gcr, r_p_bcb;

    assign w_k = matrix_coef(r_color_matrix);

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_base  <= $signed({w_y, {COEF_BITS{1'b0}}});
            r_p_rcr <= PRD_BITS'(w_k.r_cr) * PRD_BITS'(w_cr);
            r_p_gcb <= PRD_BITS'(w_k.g_cb) * PRD_BITS'(w_cb);
            r_p_gcr <= PRD_BITS'(w_k.g_cr) * PRD_BITS'(w_cr);
            r_p_bcb <= PRD_BITS'(w_k.b_cb) * PRD_BITS'(w_cb);
        end
    end

    // Stage 4: channel sums, clamped to 0..1
    function automatic logic [CHAN_BITS-1:0] clamp_chan(input logic signed [SUM_BITS-1:0] s);
        logic [CHAN_BITS-1:0] v;
        priority if (s[SUM_BITS-1]) begin
            v = '0;
        end else if (s > $signed(SUM_BITS'(CHAN_ONE))) begin
            v = CHAN_ONE;
        end else begin
            v = s[CHAN_BITS-1:0];
        end
        return v;
    endfunction

    logic signed [SUM_BITS-1:0] w_sum_r, w_sum_g, w_sum_b;
    logic [CHAN_BITS-1:0] r_chan_r, r_chan_g, r_chan_b;

    assign w_sum_r = SUM_BITS'(r_base) + SUM_BITS'(r_p_rcr);
    assign w_sum_g = SUM_BITS'(r_base) + SUM_BITS'(r_p_gcb) + SUM_BITS'(r_p_gcr);
    assign w_sum_b = SUM_BITS'(r_base) + SUM_BITS'(r_p_bcb);

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_chan_r <= clamp_chan(w_sum_r);
            r_chan_g <= clamp_chan(w_sum_g);
            r_chan_b <= clamp_chan(w_sum_b);
        end
    end

    // Stage 5: scale to output levels, round to nearest; this is the output
    // register and holds while the sink stalls.
    function automatic logic [OUT_FRACTION_BITS-1:0] to_level(input logic [CHAN_BITS-1:0] v);
        logic [LVL_PROD-1:0] p;
        p = LVL_PROD'(v) * LVL_PROD'(LVL_TOP) + LVL_PROD'(CHAN_ONE >> 1);
        return p[CHAN_BITS-1 +: OUT_FRACTION_BITS];
    endfunction

    logic [OUT_FRACTION_BITS-1:0] r_lvl_r, r_lvl_g, r_lvl_b;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_lvl_r <= to_level(r_chan_r);
            r_lvl_g <= to_level(r_chan_g);
            r_lvl_b <= to_level(r_chan_b);
        end
    end

    assign o_rgb.valid       = r_vld[NSTG-1];
    assign o_rgb.red_level   = r_lvl_r;
    assign o_rgb.green_level = r_lvl_g;
    assign o_rgb.blue_level  = r_lvl_b;

    // Checks
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");

    a_take_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_vld[0])
        else $error("accepted pixel did not enter stage 0");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && !adv[4]) |=> (r_vld[4] && $stable(r_chan_r) && $stable(r_chan_b)))
        else $error("stalled clamp stage lost or changed its beat");

    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r_chan_r <= CHAN_ONE && r_chan_g <= CHAN_ONE && r_chan_b <= CHAN_ONE))
        else $error("clamped channel above one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && !o_rgb.ready) |=> (r_vld[NSTG-1] && $stable(r_lvl_g)))
        else $error("output beat dropped during stall");

endmodule

// ===== rtl/core/ycr2rgb_norm_div.sv =====
// ----------------------------------------------------------------------------
// ycr2rgb_norm_div
// Two-stage rounding division by a small constant divisor: reciprocal
// estimate, then one compare-and-bump correction and sign restore.
// ----------------------------------------------------------------------------
module ycr2rgb_norm_div (
    input  logic                              i_clk,
    input  ycr2rgb_pkg::t_div_adv             i_adv,
    input  ycr2rgb_pkg::t_div_in              i_div,
    output logic signed [ycr2rgb_pkg::NORM_W-1:0] o_quo
);
    import ycr2rgb_pkg::*;

    localparam int PROD_BITS = NUM_BITS + RCP_BITS;
    localparam int CHK_BITS  = QUO_BITS + DEN_BITS;

    logic [PROD_BITS-1:0] w_prod;
    logic [QUO_BITS-1:0]  r_qe;
    logic [NUM_BITS-1:0]  r_num;
    logic [DEN_BITS-1:0]  r_den;
    logic                 r_neg;
    logic [CHK_BITS-1:0]  w_next_mul;
    logic [QUO_BITS-1:0]  w_quo;
    logic signed [NORM_W-1:0] r_quo;

    // Estimate is exact or one short
    assign w_prod = PROD_BITS'(i_div.num) * PROD_BITS'(i_div.rcp);

    always_ff @(posedge i_clk) begin
        if (i_adv.est) begin
            r_qe  <= w_prod[RCP_SHIFT +: QUO_BITS];
            r_num <= i_div.num;
            r_den <= i_div.den;
            r_neg <= i_div.neg;
        end
    end

    // Bump when the next multiple still fits under the numerator
    assign w_next_mul = CHK_BITS'(r_qe + QUO_BITS'(1)) * CHK_BITS'(r_den);
    assign w_quo      = r_qe + QUO_BITS'(CHK_BITS'(r_num) >= w_next_mul);

    always_ff @(posedge i_clk) begin
        if (i_adv.fix) begin
            r_quo <= r_neg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});
        end
    end

    assign o_quo = r_quo;

endmodule
